// ===== hw/rtl/lpr_pkg.sv =====
// shared types and constants of the line pixel rasterizer
`timescale 1ns / 1ps
`default_nettype none

package lpr_pkg;

    localparam int COORD_W  = 9;
    localparam int IN_W     = 8;
    localparam int ERR_W    = 11;
    localparam int COLOR_W  = 32;
    localparam int POS_W    = 6;
    localparam int SIZE_W   = 7;
    localparam int GUARD_W  = 9;
    localparam int Q_DEPTH  = 2;
    localparam int Q_PTR_W  = 1;
    localparam int Q_CNT_W  = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = 1'd1;

    // one line request after setup
    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic [COORD_W-1:0]        span_x;
        logic [COORD_W-1:0]        span_y;
        logic                      neg_x;
        logic                      neg_y;
        logic signed [ERR_W-1:0]   err;
        logic [COLOR_W-1:0]        color;
    } line_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FLUSH
    } walk_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lpr_front.sv =====
// front end: accepts line requests and works out spans, directions and initial error
`timescale 1ns / 1ps
`default_nettype none

module lpr_front
    import lpr_pkg::*;
(
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [IN_W-1:0]        s_start_x,
    input  wire logic [IN_W-1:0]        s_start_y,
    input  wire logic [IN_W-1:0]        s_end_x,
    input  wire logic [IN_W-1:0]        s_end_y,
    input  wire logic [COLOR_W-1:0]     s_color,
    input  wire logic                   q_full,
    output logic                        q_push,
    output line_cmd_t                   q_cmd
);

    logic signed [COORD_W-1:0] x0, y0, x1, y1, dx, dy;
    logic [COORD_W-1:0]        span_x, span_y;

    always_comb begin
        x0 = $signed({s_start_x[IN_W-1], s_start_x});
        y0 = $signed({s_start_y[IN_W-1], s_start_y});
        x1 = $signed({s_end_x[IN_W-1], s_end_x});
        y1 = $signed({s_end_y[IN_W-1], s_end_y});
        dx = x1 - x0;
        dy = y1 - y0;
        span_x = dx[COORD_W-1] ? COORD_W'(-dx) : COORD_W'(dx);
        span_y = dy[COORD_W-1] ? COORD_W'(-dy) : COORD_W'(dy);

        q_cmd.start_x = x0;
        q_cmd.start_y = y0;
        q_cmd.end_x   = x1;
        q_cmd.end_y   = y1;
        q_cmd.span_x  = span_x;
        q_cmd.span_y  = span_y;
        q_cmd.neg_x   = !(x0 < x1);
        q_cmd.neg_y   = !(y0 < y1);
        q_cmd.err     = $signed({{(ERR_W-COORD_W){1'b0}}, span_x})
                      - $signed({{(ERR_W-COORD_W){1'b0}}, span_y});
        q_cmd.color   = s_color;
    end

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

endmodule

`default_nettype wire

// ===== hw/rtl/lpr_queue.sv =====
// two-entry command queue between front end and walker
`timescale 1ns / 1ps
`default_nettype none

module lpr_queue
    import lpr_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push,
    input  wire line_cmd_t push_cmd,
    output logic           full,
    input  wire logic      pop,
    output logic           rd_valid,
    output line_cmd_t      rd_cmd
);

    line_cmd_t             entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]    count_reg, count_next;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign full     = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_cmd   = entry_reg[rd_ptr_reg];

endmodule

`default_nettype wire

// ===== hw/rtl/lpr_walker.sv =====
// back end: steps the error walk, clips points and issues pixel beats
`timescale 1ns / 1ps
`default_nettype none

module lpr_walker
    import lpr_pkg::*;
#(
    parameter int CANVAS_MAX = 64
)
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                q_valid,
    input  wire line_cmd_t           q_cmd,
    output logic                     q_pop,
    input  wire logic [SIZE_W-1:0]   canvas_width,
    input  wire logic [SIZE_W-1:0]   canvas_height,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [POS_W-1:0]         m_pixel_x,
    output logic [POS_W-1:0]         m_pixel_y,
    output logic [COLOR_W-1:0]       m_pixel_color,
    output logic                     m_written,
    output logic                     m_last
);

    localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(CANVAS_MAX);

    walk_state_t               state_reg, state_next;
    logic signed [COORD_W-1:0] cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic signed [COORD_W-1:0] end_x_reg, end_x_next, end_y_reg, end_y_next;
    logic [COORD_W-1:0]        span_x_reg, span_x_next, span_y_reg, span_y_next;
    logic                      neg_x_reg, neg_x_next, neg_y_reg, neg_y_next;
    logic signed [ERR_W-1:0]   err_reg, err_next;
    logic [COLOR_W-1:0]        color_reg, color_next;
    logic [GUARD_W-1:0]        guard_reg, guard_next;
    logic                      pend_valid_reg, pend_valid_next;
    logic [POS_W-1:0]          pend_x_reg, pend_x_next, pend_y_reg, pend_y_next;
    logic                      m_valid_reg, m_valid_next;
    logic [POS_W-1:0]          m_x_reg, m_x_next, m_y_reg, m_y_next;
    logic [COLOR_W-1:0]        m_color_reg, m_color_next;
    logic                      m_written_reg, m_written_next;
    logic                      m_last_reg, m_last_next;

    logic [SIZE_W-1:0]         w_lim, h_lim;
    logic                      on_canvas, at_end, walk_done, out_free, advance;
    logic signed [ERR_W:0]     sx_ext, sy_ext;
    logic signed [ERR_W-1:0]   sx_err, sy_err, err_mid, err_new;
    logic signed [COORD_W-1:0] x_new, y_new;

    always_comb begin
        w_lim = (canvas_width > MAX_SIZE) ? MAX_SIZE : canvas_width;
        h_lim = (canvas_height > MAX_SIZE) ? MAX_SIZE : canvas_height;
        on_canvas = !cur_x_reg[COORD_W-1] && !cur_y_reg[COORD_W-1]
                 && (cur_x_reg[COORD_W-2:0] < {1'b0, w_lim})
                 && (cur_y_reg[COORD_W-2:0] < {1'b0, h_lim});
        at_end    = (cur_x_reg == end_x_reg) && (cur_y_reg == end_y_reg);
        walk_done = at_end || (guard_reg == '1);
        out_free  = !m_valid_reg || m_ready;
        advance   = !(on_canvas && pend_valid_reg) || out_free;
    end

    // one error step: x decision first, y decision on the updated error
    always_comb begin
        sx_err = $signed({{(ERR_W-COORD_W){1'b0}}, span_x_reg});
        sy_err = $signed({{(ERR_W-COORD_W){1'b0}}, span_y_reg});
        sx_ext = $signed({{(ERR_W+1-COORD_W){1'b0}}, span_x_reg});
        sy_ext = $signed({{(ERR_W+1-COORD_W){1'b0}}, span_y_reg});
        err_mid = err_reg;
        x_new   = cur_x_reg;
        y_new   = cur_y_reg;
        if ($signed({err_reg, 1'b0}) > -sy_ext) begin
            err_mid = err_reg - sy_err;
            x_new   = neg_x_reg ? cur_x_reg - COORD_W'(1) : cur_x_reg + COORD_W'(1);
        end
        err_new = err_mid;
        if ($signed({err_mid, 1'b0}) < sx_ext) begin
            err_new = err_mid + sx_err;
            y_new   = neg_y_reg ? cur_y_reg - COORD_W'(1) : cur_y_reg + COORD_W'(1);
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (advance && walk_done) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        q_pop           = 1'b0;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        end_x_next      = end_x_reg;
        end_y_next      = end_y_reg;
        span_x_next     = span_x_reg;
        span_y_next     = span_y_reg;
        neg_x_next      = neg_x_reg;
        neg_y_next      = neg_y_reg;
        err_next        = err_reg;
        color_next      = color_reg;
        guard_next      = guard_reg;
        pend_valid_next = pend_valid_reg;
        pend_x_next     = pend_x_reg;
        pend_y_next     = pend_y_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_x_next        = m_x_reg;
        m_y_next        = m_y_reg;
        m_color_next    = m_color_reg;
        m_written_next  = m_written_reg;
        m_last_next     = m_last_reg;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop           = 1'b1;
                    cur_x_next      = q_cmd.start_x;
                    cur_y_next      = q_cmd.start_y;
                    end_x_next      = q_cmd.end_x;
                    end_y_next      = q_cmd.end_y;
                    span_x_next     = q_cmd.span_x;
                    span_y_next     = q_cmd.span_y;
                    neg_x_next      = q_cmd.neg_x;
                    neg_y_next      = q_cmd.neg_y;
                    err_next        = q_cmd.err;
                    color_next      = q_cmd.color;
                    guard_next      = '0;
                    pend_valid_next = 1'b0;
                end
            end
            ST_WALK: begin
                if (advance) begin
                    // hold one point back so the final one can carry last
                    if (on_canvas) begin
                        pend_valid_next = 1'b1;
                        pend_x_next     = cur_x_reg[POS_W-1:0];
                        pend_y_next     = cur_y_reg[POS_W-1:0];
                        if (pend_valid_reg) begin
                            m_valid_next   = 1'b1;
                            m_x_next       = pend_x_reg;
                            m_y_next       = pend_y_reg;
                            m_color_next   = color_reg;
                            m_written_next = 1'b1;
                            m_last_next    = 1'b0;
                        end
                    end
                    if (!walk_done) begin
                        cur_x_next = x_new;
                        cur_y_next = y_new;
                        err_next   = err_new;
                        guard_next = guard_reg + 1'b1;
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_last_next     = 1'b1;
                    m_written_next  = pend_valid_reg;
                    m_x_next        = pend_valid_reg ? pend_x_reg : '0;
                    m_y_next        = pend_valid_reg ? pend_y_reg : '0;
                    m_color_next    = pend_valid_reg ? color_reg : '0;
                    pend_valid_next = 1'b0;
                end
            end
            default: begin
                pend_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_x_reg     <= cur_x_next;
        cur_y_reg     <= cur_y_next;
        end_x_reg     <= end_x_next;
        end_y_reg     <= end_y_next;
        span_x_reg    <= span_x_next;
        span_y_reg    <= span_y_next;
        neg_x_reg     <= neg_x_next;
        neg_y_reg     <= neg_y_next;
        err_reg       <= err_next;
        color_reg     <= color_next;
        guard_reg     <= guard_next;
        pend_x_reg    <= pend_x_next;
        pend_y_reg    <= pend_y_next;
        m_x_reg       <= m_x_next;
        m_y_reg       <= m_y_next;
        m_color_reg   <= m_color_next;
        m_written_reg <= m_written_next;
        m_last_reg    <= m_last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_pixel_x     = m_x_reg;
    assign m_pixel_y     = m_y_reg;
    assign m_pixel_color = m_color_reg;
    assign m_written     = m_written_reg;
    assign m_last        = m_last_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/line_pixel_rasterizer_top.sv =====
// Line pixel rasterizer: takes a line request and issues one beat per pixel
// on the canvas, walking the Bresenham error loop from start to end inclusive.
// s_ channel: one beat per line (endpoints as signed 8-bit values, color).
// m_ channel: one beat per on-canvas pixel; last marks the final beat of a
// line; a line that misses the canvas gives a single beat with written low.
// cfg port: index 0 sets canvas width, index 1 canvas height, write while idle.
// A request lands in a two-entry queue at acceptance; the walker takes it
// from the queue once idle and visits one point per cycle unless the output
// stalls; the single walker works on one line at a time.
// The first pixel beat appears after the second on-canvas point is visited,
// since one point is held back to carry last; the final beat is registered
// in the flush state that follows the last point, once the output register
// is free. When the receiver stalls, the output register holds its beat and
// the walker waits at the next on-canvas point; the queue keeps taking
// requests until full. Reset empties the queue, drops any walk in flight and
// sets the canvas to 64 by 64.
`timescale 1ns / 1ps
`default_nettype none

module line_pixel_rasterizer_top
    import lpr_pkg::*;
#(
    parameter int CANVAS_MAX = 64
)
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [SIZE_W-1:0]     cfg_wdata,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [IN_W-1:0]       s_start_x,
    input  wire logic [IN_W-1:0]       s_start_y,
    input  wire logic [IN_W-1:0]       s_end_x,
    input  wire logic [IN_W-1:0]       s_end_y,
    input  wire logic [COLOR_W-1:0]    s_color,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [POS_W-1:0]           m_pixel_x,
    output logic [POS_W-1:0]           m_pixel_y,
    output logic [COLOR_W-1:0]         m_pixel_color,
    output logic                       m_written,
    output logic                       m_last
);

    logic [SIZE_W-1:0] canvas_width_reg, canvas_width_next;
    logic [SIZE_W-1:0] canvas_height_reg, canvas_height_next;

    logic       q_push, q_full, q_pop, q_valid;
    line_cmd_t  push_cmd, rd_cmd;

    always_comb begin
        canvas_width_next  = canvas_width_reg;
        canvas_height_next = canvas_height_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_CANVAS_WIDTH:  canvas_width_next  = cfg_wdata;
                REG_CANVAS_HEIGHT: canvas_height_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            canvas_width_reg  <= SIZE_W'(64);
            canvas_height_reg <= SIZE_W'(64);
        end else begin
            canvas_width_reg  <= canvas_width_next;
            canvas_height_reg <= canvas_height_next;
        end
    end

    lpr_front u_front (
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_start_x (s_start_x),
        .s_start_y (s_start_y),
        .s_end_x   (s_end_x),
        .s_end_y   (s_end_y),
        .s_color   (s_color),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (push_cmd)
    );

    lpr_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .rd_valid (q_valid),
        .rd_cmd   (rd_cmd)
    );

    lpr_walker #(
        .CANVAS_MAX (CANVAS_MAX)
    ) u_walker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_cmd         (rd_cmd),
        .q_pop         (q_pop),
        .canvas_width  (canvas_width_reg),
        .canvas_height (canvas_height_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_x     (m_pixel_x),
        .m_pixel_y     (m_pixel_y),
        .m_pixel_color (m_pixel_color),
        .m_written     (m_written),
        .m_last        (m_last)
    );

endmodule

`default_nettype wire
